>>> rtl/core/generational_handle_allocator_unit_macros.svh
// Assertion macros for the handle allocator.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define GHAU_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ghau assertion failed");
// next-cycle implication
`define GHAU_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ghau assertion failed");
`else
`define GHAU_ASSERT_IMP(name, ante, cons)
`define GHAU_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> rtl/core/ghau_pkg.sv
`timescale 1ns / 1ps
package ghau_pkg;

   localparam int SLOTS    = 256;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int GEN_W    = 24;
   localparam int HANDLE_W = 48;
   localparam int OP_W     = 3;
   localparam int STS_W    = 2;

   // operation codes (5..7 are no-ops)
   localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
   localparam logic [OP_W-1:0] OP_CANCEL  = 3'd1;
   localparam logic [OP_W-1:0] OP_DESTROY = 3'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd3;
   localparam logic [OP_W-1:0] OP_APPLY   = 3'd4;

   localparam logic [STS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
   localparam logic [STS_W-1:0] STS_NORES = 2'd2;

   typedef struct packed {
      logic [GEN_W-1:0] gen;
      logic             alive;
      logic             pending;
      logic             doomed;
   } slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC_RD,
      ST_EXEC,
      ST_Q_SLOT,
      ST_Q_WR,
      ST_SCAN
   } state_type;

endpackage

>>> rtl/core/ghau_ram.sv
`timescale 1ns / 1ps
module ghau_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/generational_handle_allocator_unit.sv
// Channel    Dir  Handshake              Payload
// req_       in   req_valid / req_stall  operation, handle, pending_ok
// rsp_       out  rsp_valid / rsp_stall  handle_out, status, live_count, free_count
//
// From accept to result: lookup, cancel and destroy go straight to the result
// step; allocate has a free stack read first; apply releases queued destroys,
// then scans the slot table, one slot table read per cycle. One transaction in
// flight at a time. After reset a clearing pass over all SLOTS (256) entries
// fills the slot table and free stack; req_stall stays high until it ends. A
// waiting result does not block the input; the next result holds in its last step until rsp_stall is low.
`timescale 1ns / 1ps
`include "generational_handle_allocator_unit_macros.svh"
module generational_handle_allocator_unit
   import ghau_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [HANDLE_W-1:0] req_handle,
   input  logic                req_pending_ok,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [HANDLE_W-1:0] rsp_handle_out,
   output logic [STS_W-1:0]    rsp_status,
   output logic [CNT_W-1:0]    rsp_live_count,
   output logic [CNT_W-1:0]    rsp_free_count
);

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fd_ff, fd_in;     // free stack depth
   logic [CNT_W-1:0]   adm_ff, adm_in;   // admitted, not doomed
   logic [CNT_W-1:0]   dd_ff, dd_in;     // destroy queue depth
   logic [CNT_W-1:0]   cnt_ff, cnt_in;   // clear / queue / scan pointer
   logic               dv_ff, dv_in;     // scan read data valid
   logic               rsp_valid_ff, rsp_valid_in;

   // transaction payload
   logic [OP_W-1:0]     op_ff, op_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                allow_ff, allow_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                fmt_ff, fmt_in;   // handle index field in range
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [STS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]    rsp_live_ff, rsp_live_in;
   logic [CNT_W-1:0]    rsp_free_ff, rsp_free_in;

   // memory ports
   logic                   slot_we, slot_re;
   logic [IDX_W-1:0]       slot_waddr, slot_raddr;
   slot_type               slot_wdata, slot_rd;
   logic [$bits(slot_type)-1:0] slot_rdata;
   logic                   free_we, free_re;
   logic [IDX_W-1:0]       free_waddr, free_raddr, free_wdata, free_rdata;
   logic                   dq_we, dq_re;
   logic [IDX_W-1:0]       dq_waddr, dq_raddr, dq_wdata, dq_rdata;

   logic [GEN_W-1:0]  req_low, req_low_m1;
   logic              req_fmt_ok;
   logic [CNT_W-1:0]  fd_m1, cnt_p1, cnt_m1;
   logic              out_free, resolves;

   assign slot_rd    = slot_rdata;
   assign req_low    = req_handle[GEN_W-1:0];
   assign req_low_m1 = req_low - GEN_W'(1);
   assign req_fmt_ok = (req_low != '0) && (req_low_m1 < GEN_W'(SLOTS));
   assign fd_m1      = fd_ff - CNT_W'(1);
   assign cnt_p1     = cnt_ff + CNT_W'(1);
   assign cnt_m1     = cnt_ff - CNT_W'(1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // handle matches an alive, undoomed slot (pending filtered per operation)
   assign resolves   = fmt_ff && (slot_rd.gen == handle_ff[HANDLE_W-1:GEN_W])
                       && slot_rd.alive && !slot_rd.doomed;

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_live_count = rsp_live_ff;
   assign rsp_free_count = rsp_free_ff;

   ghau_ram #(.WIDTH($bits(slot_type)), .DEPTH(SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .re    (slot_re),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   ghau_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_free_ram (
      .clock (clock),
      .we    (free_we),
      .waddr (free_waddr),
      .wdata (free_wdata),
      .re    (free_re),
      .raddr (free_raddr),
      .rdata (free_rdata)
   );

   ghau_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_dq_ram (
      .clock (clock),
      .we    (dq_we),
      .waddr (dq_waddr),
      .wdata (dq_wdata),
      .re    (dq_re),
      .raddr (dq_raddr),
      .rdata (dq_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         fd_ff        <= CNT_W'(SLOTS);
         adm_ff       <= '0;
         dd_ff        <= '0;
         cnt_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fd_ff        <= fd_in;
         adm_ff       <= adm_in;
         dd_ff        <= dd_in;
         cnt_ff       <= cnt_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      handle_ff     <= handle_in;
      allow_ff      <= allow_in;
      idx_ff        <= idx_in;
      fmt_ff        <= fmt_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_free_ff   <= rsp_free_in;
   end

   always_comb begin
      state_in      = state_ff;
      fd_in         = fd_ff;
      adm_in        = adm_ff;
      dd_in         = dd_ff;
      cnt_in        = cnt_ff;
      dv_in         = 1'b0;
      op_in         = op_ff;
      handle_in     = handle_ff;
      allow_in      = allow_ff;
      idx_in        = idx_ff;
      fmt_in        = fmt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_free_in   = rsp_free_ff;

      slot_we    = 1'b0;
      slot_waddr = idx_ff;
      slot_wdata = slot_rd;
      slot_re    = 1'b0;
      slot_raddr = '0;
      free_we    = 1'b0;
      free_waddr = fd_ff[IDX_W-1:0];
      free_wdata = idx_ff;
      free_re    = 1'b0;
      free_raddr = fd_m1[IDX_W-1:0];
      dq_we      = 1'b0;
      dq_waddr   = dd_ff[IDX_W-1:0];
      dq_wdata   = idx_ff;
      dq_re      = 1'b0;
      dq_raddr   = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // zero the slot table, load the free stack with lowest index on top
            slot_we    = 1'b1;
            slot_waddr = cnt_ff[IDX_W-1:0];
            slot_wdata = '0;
            free_we    = 1'b1;
            free_waddr = cnt_ff[IDX_W-1:0];
            free_wdata = IDX_W'(SLOTS - 1) - cnt_ff[IDX_W-1:0];
            if (cnt_ff == CNT_W'(SLOTS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_p1;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_operation;
               handle_in  = req_handle;
               allow_in   = req_pending_ok;
               fmt_in     = req_fmt_ok;
               idx_in     = req_low_m1[IDX_W-1:0];
               // speculative reads: slot of the handle, top of stack, queue head
               slot_re    = 1'b1;
               slot_raddr = req_low_m1[IDX_W-1:0];
               free_re    = 1'b1;
               dq_re      = 1'b1;
               cnt_in     = '0;
               priority if (req_operation == OP_ALLOC && fd_ff != '0) begin
                  state_in = ST_ALLOC_RD;
               end else if (req_operation == OP_APPLY && dd_ff != '0) begin
                  state_in = ST_Q_SLOT;
               end else if (req_operation == OP_APPLY) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_ALLOC_RD: begin
            idx_in     = free_rdata;
            slot_re    = 1'b1;
            slot_raddr = free_rdata;
            state_in   = ST_EXEC;
         end

         ST_Q_SLOT: begin
            idx_in     = dq_rdata;
            slot_re    = 1'b1;
            slot_raddr = dq_rdata;
            state_in   = ST_Q_WR;
         end

         ST_Q_WR: begin
            // release one queued slot in request order
            if (slot_rd.alive) begin
               slot_we    = 1'b1;
               slot_wdata = '{gen: slot_rd.gen + GEN_W'(1), alive: 1'b0,
                              pending: 1'b0, doomed: 1'b0};
               if (fd_ff < CNT_W'(SLOTS)) begin
                  free_we = 1'b1;
                  fd_in   = fd_ff + CNT_W'(1);
               end
            end
            if (cnt_p1 == dd_ff) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end else begin
               cnt_in   = cnt_p1;
               dq_re    = 1'b1;
               dq_raddr = cnt_p1[IDX_W-1:0];
               state_in = ST_Q_SLOT;
            end
         end

         ST_SCAN: begin
            // read slot cnt while writing back slot cnt-1
            if (dv_ff && slot_rd.alive && slot_rd.pending && !slot_rd.doomed) begin
               slot_we    = 1'b1;
               slot_waddr = cnt_m1[IDX_W-1:0];
               slot_wdata = '{gen: slot_rd.gen, alive: 1'b1,
                              pending: 1'b0, doomed: 1'b0};
               if (adm_ff < CNT_W'(SLOTS)) begin
                  adm_in = adm_ff + CNT_W'(1);
               end
            end
            if (cnt_ff != CNT_W'(SLOTS)) begin
               slot_re    = 1'b1;
               slot_raddr = cnt_ff[IDX_W-1:0];
               cnt_in     = cnt_p1;
               dv_in      = 1'b1;
            end else if (!dv_ff) begin
               dd_in    = '0;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_status_in = STS_OK;
               state_in      = ST_IDLE;
               unique case (op_ff)
                  OP_ALLOC: begin
                     if (fd_ff == '0) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        slot_we       = 1'b1;
                        slot_wdata    = '{gen: slot_rd.gen, alive: 1'b1,
                                          pending: 1'b1, doomed: 1'b0};
                        fd_in         = fd_m1;
                        rsp_handle_in = {slot_rd.gen, GEN_W'(idx_ff) + GEN_W'(1)};
                     end
                  end
                  OP_CANCEL: begin
                     if (resolves && slot_rd.pending) begin
                        slot_we    = 1'b1;
                        slot_wdata = '{gen: slot_rd.gen + GEN_W'(1), alive: 1'b0,
                                       pending: 1'b0, doomed: 1'b0};
                        if (fd_ff < CNT_W'(SLOTS)) begin
                           free_we = 1'b1;
                           fd_in   = fd_ff + CNT_W'(1);
                        end
                     end else begin
                        rsp_status_in = STS_NORES;
                     end
                  end
                  OP_DESTROY: begin
                     if (resolves) begin
                        if (dd_ff < CNT_W'(SLOTS)) begin
                           dq_we = 1'b1;
                           dd_in = dd_ff + CNT_W'(1);
                        end
                        slot_we    = 1'b1;
                        slot_wdata = '{gen: slot_rd.gen, alive: slot_rd.alive,
                                       pending: slot_rd.pending, doomed: 1'b1};
                        // a pending slot was never counted as live
                        if (!slot_rd.pending && adm_ff != '0) begin
                           adm_in = adm_ff - CNT_W'(1);
                        end
                     end else begin
                        rsp_status_in = STS_NORES;
                     end
                  end
                  OP_LOOKUP: begin
                     if (resolves && (!slot_rd.pending || allow_ff)) begin
                        rsp_handle_in = handle_ff;
                     end else begin
                        rsp_status_in = STS_NORES;
                     end
                  end
                  default: begin
                     // apply finished in the scan; unknown codes do nothing
                  end
               endcase
               rsp_live_in = adm_in;
               rsp_free_in = fd_in;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `GHAU_ASSERT_IMP(a_free_bound, 1'b1, fd_ff <= CNT_W'(SLOTS))
   `GHAU_ASSERT_IMP(a_occupancy, 1'b1, {1'b0, adm_ff} + {1'b0, fd_ff} <= (CNT_W+1)'(SLOTS))
   `GHAU_ASSERT_IMP(a_idle_quiet, state_ff == ST_IDLE, !slot_we && !free_we && !dq_we)
   `GHAU_ASSERT_IMP(a_scan_data, dv_ff, state_ff == ST_SCAN)
   `GHAU_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_ff != ST_IDLE)

endmodule
